// File: rtl/line_tokenizer_quotes_comments_macros.svh
// Assertion macros of the tokenizer checker.
`ifndef LINE_TOKENIZER_QUOTES_COMMENTS_MACROS_SVH
`define LINE_TOKENIZER_QUOTES_COMMENTS_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define LT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lt_pkg.sv
// Shared types, constants and match functions of the line tokenizer.
`default_nettype none

package lt_pkg;

	localparam int unsigned MAX_TOKEN_CHARS = 8;
	localparam int unsigned MAX_QUOTE_PAIRS = MAX_TOKEN_CHARS / 2;
	localparam int unsigned MAX_PENDING_CR  = 7;
	localparam int unsigned CR_HOLD_LIMIT   = (MAX_PENDING_CR < 7) ? MAX_PENDING_CR : 7;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic [2:0] REG_DELIM_CHARS   = 3'd0;
	localparam logic [2:0] REG_DELIM_COUNT   = 3'd1;
	localparam logic [2:0] REG_COMMENT_CHARS = 3'd2;
	localparam logic [2:0] REG_COMMENT_COUNT = 3'd3;
	localparam logic [2:0] REG_QUOTE_CHARS   = 3'd4;
	localparam logic [2:0] REG_QUOTE_COUNT   = 3'd5;
	localparam logic [2:0] REG_TRIM_SPACES   = 3'd6;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_TOKEN,
		MODE_QUOTED,
		MODE_COMMENT
	} mode_t;

	typedef enum logic [1:0] {
		SLOT_NONE,
		SLOT_CHAR,
		SLOT_TE
	} slot_t;

	typedef struct packed {
		logic [63:0] delim_chars;
		logic [3:0]  delim_n;
		logic [63:0] comment_chars;
		logic [3:0]  comment_n;
		logic [63:0] quote_chars;
		logic [2:0]  quote_n;
		logic        trim;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  close_quote;
		logic        held_valid;
		logic [7:0]  held_byte;
		logic [2:0]  pending_cr;
		logic        token_nonempty;
	} parse_state_t;

	// Results of one byte: an optional result from the held byte, a run of
	// released CRs, an optional result from the byte itself, then line end.
	typedef struct packed {
		slot_t       a_kind;
		logic [7:0]  a_char;
		logic [2:0]  cr_n;
		slot_t       c_kind;
		logic [7:0]  c_char;
		logic        line_done;
		logic        merge;
		logic        line_te;
		logic [3:0]  count;
	} plan_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       te;
		logic       le;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] close;
	} quote_hit_t;

	function automatic logic [7:0] byte_at(input logic [63:0] w, input int unsigned k);
		byte_at = w[8 * (k & 32'd7) +: 8];
	endfunction

	function automatic logic is_delim(input logic [7:0] b, input logic [63:0] chars,
	                                  input logic [3:0] n);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < MAX_TOKEN_CHARS; k++) begin
			if (4'(k) < n && b == byte_at(chars, k)) begin
				hit = 1'b1;
			end
		end
		is_delim = hit;
	endfunction

	// An entry equal to its next entry forms a doubled token, which needs the
	// next byte to match as well; when it does not, the partner is skipped.
	function automatic logic comment_eval(input logic [7:0] b, input logic last,
	                                      input logic [7:0] nx, input logic [63:0] chars,
	                                      input logic [3:0] n);
		logic hit;
		logic skip;
		hit  = 1'b0;
		skip = 1'b0;
		for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
			if (skip) begin
				skip = 1'b0;
			end else if (4'(i) < n && b == byte_at(chars, i)) begin
				if (!last && 4'(i + 1) < n && byte_at(chars, i + 1) == b) begin
					if (nx == b) begin
						hit = 1'b1;
					end else begin
						skip = 1'b1;
					end
				end else begin
					hit = 1'b1;
				end
			end
		end
		comment_eval = hit;
	endfunction

	function automatic quote_hit_t open_quote(input logic [7:0] b, input logic [63:0] chars,
	                                          input logic [2:0] n);
		quote_hit_t r;
		r = '0;
		// Scan downward so that the lowest matching pair wins.
		for (int p = MAX_QUOTE_PAIRS - 1; p >= 0; p--) begin
			if (3'(p) < n && b == byte_at(chars, 2 * p)) begin
				r.hit   = 1'b1;
				r.close = byte_at(chars, 2 * p + 1);
			end
		end
		open_quote = r;
	endfunction

	function automatic logic is_dropped(input logic [7:0] b, input logic trim);
		is_dropped = (b == CH_CR) || (trim && (b == CH_SP || b == CH_TAB));
	endfunction

endpackage

`default_nettype wire

// File: rtl/line_tokenizer_quotes_comments.sv
// Top level of the streaming line tokenizer with quotes and comments.
//
// Text enters one byte per beat on in_valid/in_stall with in_byte and
// end_of_buffer; a beat is taken when in_valid is high and in_stall is low.
// Results leave one per beat on out_valid/out_stall with out_char, char_valid,
// token_end, line_end and run_last; run_last marks the final result of a byte.
// Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; the user must write only while the block is idle (not enforced).
//
// A byte is taken into the input register; its first result is then loaded
// into the output register once that register can load. A byte that yields
// zero or one result frees the input register once that result, if any, is
// issued, so such bytes stream at one per cycle while the receiver does not
// stall; one with more holds it while the single output register issues them.
//
// Reset clears the registers, the parse state and the valid flags of both
// pipeline registers.
// While the receiver stalls, the output beat holds; the input register then
// fills and in_stall rises until the output register can move again.
`default_nettype none

module line_tokenizer_quotes_comments import lt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_char,
	output logic             char_valid,
	output logic             token_end,
	output logic             line_end,
	output logic             run_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	cfg_t         cfg;
	parse_state_t state_q;
	parse_state_t state_nx;
	plan_t        plan;
	result_t      res;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eob_s1;
	logic         consume;
	logic         accept;

	assign cfg_ready = 1'b1;

	lt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	lt_step u_step (
		.cfg  (cfg),
		.st   (state_q),
		.b    (byte_s1),
		.eob  (eob_s1),
		.plan (plan),
		.nx   (state_nx)
	);

	// The parse state advances once the last result of the byte is issued, or when the byte yields none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nx;
		end
	end

	lt_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.plan       (plan),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res        (res),
		.consume    (consume)
	);

	assign out_char   = res.ch;
	assign char_valid = res.cv;
	assign token_end  = res.te;
	assign line_end   = res.le;
	assign run_last   = res.last;

endmodule

`default_nettype wire

// File: rtl/lt_cfg_regs.sv
// Configuration registers of the line tokenizer with count saturation.
`default_nettype none

module lt_cfg_regs import lt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output cfg_t             cfg
);

	logic [63:0] delim_chars_q;
	logic [3:0]  delim_cnt_q;
	logic [63:0] comment_chars_q;
	logic [3:0]  comment_cnt_q;
	logic [63:0] quote_chars_q;
	logic [2:0]  quote_cnt_q;
	logic        trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_chars_q   <= '0;
			delim_cnt_q     <= '0;
			comment_chars_q <= '0;
			comment_cnt_q   <= '0;
			quote_chars_q   <= '0;
			quote_cnt_q     <= '0;
			trim_q          <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELIM_CHARS:   delim_chars_q   <= cfg_data;
				REG_DELIM_COUNT:   delim_cnt_q     <= cfg_data[3:0];
				REG_COMMENT_CHARS: comment_chars_q <= cfg_data;
				REG_COMMENT_COUNT: comment_cnt_q   <= cfg_data[3:0];
				REG_QUOTE_CHARS:   quote_chars_q   <= cfg_data;
				REG_QUOTE_COUNT:   quote_cnt_q     <= cfg_data[2:0];
				REG_TRIM_SPACES:   trim_q          <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.delim_chars   = delim_chars_q;
		cfg.delim_n       = (delim_cnt_q > 4'(MAX_TOKEN_CHARS)) ? 4'(MAX_TOKEN_CHARS)
		                                                       : delim_cnt_q;
		cfg.comment_chars = comment_chars_q;
		cfg.comment_n     = (comment_cnt_q > 4'(MAX_TOKEN_CHARS)) ? 4'(MAX_TOKEN_CHARS)
		                                                         : comment_cnt_q;
		cfg.quote_chars   = quote_chars_q;
		cfg.quote_n       = (quote_cnt_q > 3'(MAX_QUOTE_PAIRS)) ? 3'(MAX_QUOTE_PAIRS)
		                                                       : quote_cnt_q;
		cfg.trim          = trim_q;
	end

endmodule

`default_nettype wire

// File: rtl/lt_step.sv
// Per-byte parse decision: the result plan of one byte and the next parse state.
`default_nettype none

module lt_step import lt_pkg::*; (
	input  cfg_t             cfg,
	input  parse_state_t     st,
	input  wire logic [7:0]  b,
	input  wire logic        eob,
	output plan_t            plan,
	output parse_state_t     nx
);

	logic       eol;
	logic       ce_held;
	logic       ce_same;
	logic       ce_flip;
	logic       ce_last;
	logic       delim_b;
	logic       drop_h;
	logic       drop_b;
	quote_hit_t qh_h;
	quote_hit_t qh_b;

	assign eol     = (b == CH_LF) || (b == CH_NUL);
	assign ce_held = comment_eval(st.held_byte, 1'b0, b, cfg.comment_chars, cfg.comment_n);
	assign ce_same = comment_eval(b, 1'b0, b, cfg.comment_chars, cfg.comment_n);
	assign ce_flip = comment_eval(b, 1'b0, b ^ 8'h01, cfg.comment_chars, cfg.comment_n);
	assign ce_last = comment_eval(b, eob, b, cfg.comment_chars, cfg.comment_n);
	assign delim_b = is_delim(b, cfg.delim_chars, cfg.delim_n);
	assign drop_h  = is_dropped(st.held_byte, cfg.trim);
	assign drop_b  = is_dropped(b, cfg.trim);
	assign qh_h    = open_quote(st.held_byte, cfg.quote_chars, cfg.quote_n);
	assign qh_b    = open_quote(b, cfg.quote_chars, cfg.quote_n);

	always_comb begin
		logic last_is_char;
		nx   = st;
		plan = '0;

		// A held comment candidate is settled by the byte that follows it.
		if (st.held_valid) begin
			nx.held_valid = 1'b0;
			if (eol || ce_held) begin
				if (nx.mode == MODE_TOKEN) begin
					if (nx.token_nonempty) begin
						plan.a_kind = SLOT_TE;
					end
					nx.token_nonempty = 1'b0;
					nx.pending_cr     = '0;
				end
				nx.mode = MODE_COMMENT;
			end else if (nx.mode == MODE_IDLE && qh_h.hit) begin
				nx.mode           = MODE_QUOTED;
				nx.close_quote    = qh_h.close;
				nx.token_nonempty = 1'b0;
				nx.pending_cr     = '0;
			end else begin
				nx.mode = MODE_TOKEN;
				if (!drop_h) begin
					plan.a_kind       = SLOT_CHAR;
					plan.a_char       = st.held_byte;
					nx.token_nonempty = 1'b1;
				end
			end
		end

		if (!eol) begin
			if (nx.mode == MODE_QUOTED) begin
				if (b == nx.close_quote) begin
					if (nx.token_nonempty) begin
						plan.c_kind = SLOT_TE;
					end
					nx.token_nonempty = 1'b0;
					nx.pending_cr     = '0;
					nx.mode           = MODE_IDLE;
				end else if (b == CH_CR) begin
					if (nx.pending_cr < 3'(CR_HOLD_LIMIT)) begin
						nx.pending_cr = nx.pending_cr + 3'd1;
					end else begin
						plan.c_kind       = SLOT_CHAR;
						plan.c_char       = CH_CR;
						nx.token_nonempty = 1'b1;
					end
				end else begin
					// Held CRs are released ahead of real content.
					plan.cr_n         = nx.pending_cr;
					nx.pending_cr     = '0;
					plan.c_kind       = SLOT_CHAR;
					plan.c_char       = b;
					nx.token_nonempty = 1'b1;
				end
			end else if (nx.mode != MODE_COMMENT) begin
				if (delim_b) begin
					if (nx.mode == MODE_TOKEN) begin
						if (nx.token_nonempty) begin
							plan.c_kind = SLOT_TE;
						end
						nx.token_nonempty = 1'b0;
						nx.pending_cr     = '0;
					end
					nx.mode = MODE_IDLE;
				end else if (!eob && (ce_same != ce_flip)) begin
					nx.held_valid = 1'b1;
					nx.held_byte  = b;
				end else if (ce_last) begin
					if (nx.mode == MODE_TOKEN) begin
						if (nx.token_nonempty) begin
							plan.c_kind = SLOT_TE;
						end
						nx.token_nonempty = 1'b0;
						nx.pending_cr     = '0;
					end
					nx.mode = MODE_COMMENT;
				end else if (nx.mode == MODE_IDLE && qh_b.hit) begin
					nx.mode           = MODE_QUOTED;
					nx.close_quote    = qh_b.close;
					nx.token_nonempty = 1'b0;
					nx.pending_cr     = '0;
				end else begin
					nx.mode = MODE_TOKEN;
					if (!drop_b) begin
						plan.c_kind       = SLOT_CHAR;
						plan.c_char       = b;
						nx.token_nonempty = 1'b1;
					end
				end
			end
		end

		// Released CRs always come with a content byte, so the last result
		// is a character exactly in these cases.
		last_is_char = (plan.c_kind == SLOT_CHAR) ||
		               (plan.c_kind == SLOT_NONE && plan.a_kind == SLOT_CHAR);

		if (eol || eob) begin
			plan.line_done = 1'b1;
			plan.merge     = last_is_char;
			plan.line_te   = nx.token_nonempty;
			nx             = '0;
		end

		plan.count = {3'b000, plan.a_kind != SLOT_NONE} + {1'b0, plan.cr_n} +
		             {3'b000, plan.c_kind != SLOT_NONE} +
		             {3'b000, plan.line_done && !plan.merge};
	end

endmodule

`default_nettype wire

// File: rtl/lt_out_stage.sv
// Result sequencer and output register: issues the planned results one per beat.
`default_nettype none

module lt_out_stage import lt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  plan_t      plan,
	input  wire logic  out_stall,
	output logic       out_valid,
	output result_t    res,
	output logic       consume
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	result_t    res_q;
	result_t    pick;
	logic       load;
	logic       last_k;
	logic       issue;
	logic       has_a;
	logic [3:0] j;

	function automatic result_t slot_result(input slot_t kind, input logic [7:0] ch);
		result_t r;
		r = '0;
		unique case (kind)
			SLOT_CHAR: begin
				r.ch = ch;
				r.cv = 1'b1;
			end
			SLOT_TE: r.te = 1'b1;
			default: begin
			end
		endcase
		slot_result = r;
	endfunction

	assign load    = !out_valid_q || !out_stall;
	assign last_k  = (idx_q == plan.count - 4'd1);
	assign issue   = item_valid && (plan.count != 4'd0) && load;
	assign consume = item_valid && ((plan.count == 4'd0) || (load && last_k));
	assign has_a   = (plan.a_kind != SLOT_NONE);
	assign j       = idx_q - {3'b000, has_a};

	always_comb begin
		pick = '0;
		if (has_a && idx_q == 4'd0) begin
			pick = slot_result(plan.a_kind, plan.a_char);
		end else if (j < {1'b0, plan.cr_n}) begin
			pick.ch = CH_CR;
			pick.cv = 1'b1;
		end else if (j == {1'b0, plan.cr_n} && plan.c_kind != SLOT_NONE) begin
			pick = slot_result(plan.c_kind, plan.c_char);
		end else begin
			pick.le = 1'b1;
			pick.te = plan.line_te;
		end
		if (last_k) begin
			pick.last = 1'b1;
			// A line that ends on a character closes its token on that beat.
			if (plan.merge) begin
				pick.le = 1'b1;
				pick.te = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= last_k ? 4'd0 : idx_q + 4'd1;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			res_q <= pick;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: rtl/lt_checker.sv
// Port-level checker for the line tokenizer, bound to the top level.
`default_nettype none

`include "line_tokenizer_quotes_comments_macros.svh"

module lt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_char,
	input wire logic        char_valid,
	input wire logic        token_end,
	input wire logic        line_end,
	input wire logic        run_last
);

	logic [11:0] payload;
	logic        stalled;
	logic        taken;
	logic        char_te;

	assign payload = {out_char, char_valid, token_end, line_end, run_last};
	assign stalled = out_valid && out_stall;
	assign taken   = out_valid && !out_stall;
	assign char_te = out_valid && char_valid && token_end;

	// A stalled beat keeps its whole payload.
	`LT_ASSERT(a_stall_hold, stalled |=> out_valid && $stable(payload), "stalled beat changed")

	// The results of one byte follow each other without a gap.
	`LT_ASSERT(a_run_gapless, taken && !run_last |=> out_valid, "gap in the results of a byte")

	// Line end is always the final result of its byte.
	`LT_ASSERT(a_line_last, out_valid && line_end |-> run_last, "line end before the last result")

	// A character beat closes a token only when the line ends there too.
	`LT_ASSERT(a_char_te, char_te |-> line_end, "token end on a character without line end")

	`LT_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind line_tokenizer_quotes_comments lt_checker u_lt_checker (.*);

`default_nettype wire

// File: verif/line_tokenizer_quotes_comments_tb.sv
// Self-checking testbench: random and directed text through the line tokenizer, checked per beat.
`timescale 1ns / 1ps

module line_tokenizer_quotes_comments_tb;
	import lt_pkg::*;

	localparam int STEP_MAX   = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_BEATS = 30;

	typedef struct packed {
		logic [7:0] text;
		logic       eob;
	} text_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_char;
	logic        char_valid;
	logic        token_end;
	logic        line_end;
	logic        run_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_DELIM_CHARS;
	logic [63:0] cfg_data = 64'd0;

	line_tokenizer_quotes_comments DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid), .out_stall(out_stall), .out_char(out_char),
		.char_valid(char_valid), .token_end(token_end), .line_end(line_end),
		.run_last(run_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register copies and parse state of the tokenizer model.
	logic [63:0] dl_chars, cm_chars, qt_chars;
	logic [3:0]  dl_count, cm_count;
	logic [2:0]  qt_pairs;
	logic        trim_on;
	mode_t       tok_mode;
	logic [7:0]  close_char;
	logic        held_v;
	logic [7:0]  held_char;
	int unsigned cr_held;
	logic        tok_nonempty;

	result_t     step_res[STEP_MAX];
	int          step_n;
	result_t     expected_results[$];
	text_beat_t  text_beats[$];
	text_beat_t  next_beat;
	int          errors = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          phase_items = 0;
	int          idle_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] lane(input logic [63:0] w, input int k);
		return w[8 * (k % 8) +: 8];
	endfunction

	function automatic int clip(input int n, input int lim);
		return (n < lim) ? n : lim;
	endfunction

	function automatic void note_result(input logic [7:0] ch, input logic cv, input logic te,
	                                    input logic le);
		if (step_n < STEP_MAX) begin
			step_res[step_n].ch   = cv ? ch : 8'h00;
			step_res[step_n].cv   = cv;
			step_res[step_n].te   = te;
			step_res[step_n].le   = le;
			step_res[step_n].last = 1'b0;
			step_n++;
		end
	endfunction

	function automatic logic delim_hit(input logic [7:0] b);
		int n;
		n = clip(int'(dl_count), MAX_TOKEN_CHARS);
		for (int k = 0; k < n; k++)
			if (b == lane(dl_chars, k))
				return 1'b1;
		return 1'b0;
	endfunction

	// A doubled entry needs the following byte to match too; if it does not,
	// the partner entry is skipped as well.
	function automatic logic comment_hit(input logic [7:0] b, input logic last,
	                                     input logic [7:0] nxt);
		int n, i;
		n = clip(int'(cm_count), MAX_TOKEN_CHARS);
		i = 0;
		while (i < n) begin
			if (b == lane(cm_chars, i)) begin
				if (!last && i + 1 < n && lane(cm_chars, i + 1) == b) begin
					if (nxt == b)
						return 1'b1;
					i += 2;
				end else begin
					return 1'b1;
				end
			end else begin
				i++;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic quote_open_hit(input logic [7:0] b, output logic [7:0] cq);
		int n;
		n = clip(int'(qt_pairs), MAX_QUOTE_PAIRS);
		cq = 8'h00;
		for (int p = 0; p < n; p++) begin
			if (b == lane(qt_chars, 2 * p)) begin
				cq = lane(qt_chars, 2 * p + 1);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void close_token();
		if (tok_nonempty)
			note_result(8'h00, 1'b0, 1'b1, 1'b0);
		tok_nonempty = 1'b0;
		cr_held = 0;
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		logic [7:0] cq;
		if (tok_mode == MODE_IDLE && quote_open_hit(b, cq)) begin
			tok_mode = MODE_QUOTED;
			close_char = cq;
			tok_nonempty = 1'b0;
			cr_held = 0;
		end else begin
			tok_mode = MODE_TOKEN;
			if (!(b == CH_CR || (trim_on && (b == CH_SP || b == CH_TAB)))) begin
				note_result(b, 1'b1, 1'b0, 1'b0);
				tok_nonempty = 1'b1;
			end
		end
	endfunction

	function automatic void outside_quote_byte(input logic [7:0] b, input logic last);
		if (delim_hit(b)) begin
			if (tok_mode == MODE_TOKEN)
				close_token();
			tok_mode = MODE_IDLE;
		end else if (!last && comment_hit(b, 1'b0, b) != comment_hit(b, 1'b0, b ^ 8'h01)) begin
			// The comment decision hangs on the next byte.
			held_v = 1'b1;
			held_char = b;
		end else if (comment_hit(b, last, b)) begin
			if (tok_mode == MODE_TOKEN)
				close_token();
			tok_mode = MODE_COMMENT;
		end else begin
			plain_byte(b);
		end
	endfunction

	function automatic void in_quote_byte(input logic [7:0] b);
		if (b == close_char) begin
			close_token();
			tok_mode = MODE_IDLE;
		end else if (b == CH_CR) begin
			if (cr_held < CR_HOLD_LIMIT) begin
				cr_held++;
			end else begin
				note_result(CH_CR, 1'b1, 1'b0, 1'b0);
				tok_nonempty = 1'b1;
			end
		end else begin
			while (cr_held > 0) begin
				note_result(CH_CR, 1'b1, 1'b0, 1'b0);
				cr_held--;
			end
			note_result(b, 1'b1, 1'b0, 1'b0);
			tok_nonempty = 1'b1;
		end
	endfunction

	function automatic void clear_parse();
		tok_mode = MODE_IDLE;
		close_char = 8'h00;
		held_v = 1'b0;
		held_char = 8'h00;
		cr_held = 0;
		tok_nonempty = 1'b0;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic eob);
		logic eol;
		logic [7:0] h;
		eol = (b == CH_LF || b == CH_NUL);
		step_n = 0;
		if (held_v) begin
			h = held_char;
			held_v = 1'b0;
			if (eol || comment_hit(h, 1'b0, b)) begin
				if (tok_mode == MODE_TOKEN)
					close_token();
				tok_mode = MODE_COMMENT;
			end else begin
				plain_byte(h);
			end
		end
		if (!eol) begin
			if (tok_mode == MODE_QUOTED)
				in_quote_byte(b);
			else if (tok_mode != MODE_COMMENT)
				outside_quote_byte(b, eob);
		end
		if (eol || eob) begin
			// Line end folds into a trailing token character when there is one.
			if (step_n > 0 && step_res[step_n - 1].cv && !step_res[step_n - 1].te &&
			    !step_res[step_n - 1].le) begin
				step_res[step_n - 1].te = tok_nonempty;
				step_res[step_n - 1].le = 1'b1;
			end else begin
				note_result(8'h00, 1'b0, tok_nonempty, 1'b1);
			end
			clear_parse();
		end
		if (step_n > 0)
			step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_results = {expected_results, step_res[i]};
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result();
		result_t got, want;
		got.ch   = out_char;
		got.cv   = char_valid;
		got.te   = token_end;
		got.le   = line_end;
		got.last = run_last;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none actual %h", $time, got);
			errors++;
		end else begin
			want = expected_results.pop_front();
			check_field("out_char", want.ch, got.ch);
			check_field("char_valid", 8'(want.cv), 8'(got.cv));
			check_field("token_end", 8'(want.te), 8'(got.te));
			check_field("line_end", 8'(want.le), 8'(got.le));
			check_field("run_last", 8'(want.last), 8'(got.last));
		end
	endfunction

	// Text driver: a beat holds while stalled; new beats follow the sender idle rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				tokenize_byte(in_byte, end_of_buffer);
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (text_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				next_beat = text_beats.pop_front();
				in_valid <= 1'b1;
				in_byte <= next_beat.text;
				end_of_buffer <= next_beat.eob;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** line_tokenizer_quotes_comments: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELIM_CHARS:   dl_chars = data;
			REG_DELIM_COUNT:   dl_count = data[3:0];
			REG_COMMENT_CHARS: cm_chars = data;
			REG_COMMENT_COUNT: cm_count = data[3:0];
			REG_QUOTE_CHARS:   qt_chars = data;
			REG_QUOTE_COUNT:   qt_pairs = data[2:0];
			REG_TRIM_SPACES:   trim_on = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [63:0] dc, input logic [3:0] dn,
	                             input logic [63:0] cc, input logic [3:0] cn,
	                             input logic [63:0] qc, input logic [2:0] qn, input logic tr);
		write_reg(REG_DELIM_CHARS, dc);
		write_reg(REG_DELIM_COUNT, 64'(dn));
		write_reg(REG_COMMENT_CHARS, cc);
		write_reg(REG_COMMENT_COUNT, 64'(cn));
		write_reg(REG_QUOTE_CHARS, qc);
		write_reg(REG_QUOTE_COUNT, 64'(qn));
		write_reg(REG_TRIM_SPACES, 64'(tr));
	endtask

	// Waits until every beat is through, then lets the pipeline settle.
	// Sampling on the falling edge sees the beats launched at the rising edge.
	task automatic drain();
		do @(negedge clk);
		while (text_beats.size() != 0 || in_valid || out_valid || expected_results.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_idle(input int m);
		case (m)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
			default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
		endcase
	endtask

	function automatic void push_beat(input logic [7:0] b, input logic eob);
		text_beat_t tb_beat;
		tb_beat.text = b;
		tb_beat.eob = eob;
		text_beats = {text_beats, tb_beat};
		phase_items++;
	endfunction

	// Kind 0 draws delimiter-like bytes, kind 1 comment bytes with frequent
	// doubled neighbours, kind 2 open and close quote pairs.
	function automatic logic [63:0] pool_word(input int kind);
		string dl_pool, cm_pool, q_open, q_close;
		logic [63:0] w;
		logic [7:0] c;
		int q;
		dl_pool = ",;| \t";
		cm_pool = "#/;!";
		q_open = "\"['<";
		q_close = "\"]'>";
		w = '0;
		q = 0;
		for (int k = 0; k < 8; k++) begin
			case (kind)
				0: c = dl_pool[$urandom_range(0, dl_pool.len() - 1)];
				1: begin
					c = cm_pool[$urandom_range(0, cm_pool.len() - 1)];
					if (k % 2 == 1 && $urandom_range(0, 1) == 1)
						c = lane(w, k - 1);
				end
				default: begin
					if (k % 2 == 0)
						q = $urandom_range(0, 3);
					c = (k % 2 == 0) ? q_open[q] : q_close[q];
				end
			endcase
			if ($urandom_range(0, 7) == 0)
				c = 8'($urandom_range(0, 255));
			w[8 * k +: 8] = c;
		end
		return w;
	endfunction

	function automatic logic [7:0] pick_lane(input logic [63:0] w, input int n,
	                                         input logic [7:0] fallback);
		if (n == 0)
			return fallback;
		return lane(w, $urandom_range(0, n - 1));
	endfunction

	function automatic logic [7:0] letter();
		return 8'($urandom_range(97, 122));
	endfunction

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)  return letter();
		if (r == 13) return CH_SP;
		if (r == 14) return CH_TAB;
		if (r == 15) return CH_CR;
		if (r < 18)  return lane(qt_chars, 2 * $urandom_range(0, 3));
		if (r == 18) return lane(cm_chars, $urandom_range(0, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] noise_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)  return lane(dl_chars, $urandom_range(0, 7));
		if (r < 4)  return lane(cm_chars, $urandom_range(0, 7));
		if (r < 6)  return lane(qt_chars, $urandom_range(0, 7));
		if (r < 8)  return CH_CR;
		if (r == 8) return CH_SP;
		if (r == 9) return CH_TAB;
		if (r == 10) return CH_LF;
		if (r == 11) return CH_NUL;
		return 8'($urandom_range(0, 255));
	endfunction

	// One well-formed line: tokens, plain or quoted, an optional comment and a terminator.
	task automatic gen_line();
		logic [7:0] line_q[$];
		logic [7:0] c;
		int ntok, r, q, nq;
		logic eob_end;
		ntok = $urandom_range(0, 4);
		nq = clip(int'(qt_pairs), MAX_QUOTE_PAIRS);
		for (int t = 0; t < ntok; t++) begin
			if (t > 0 || $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					line_q = {line_q,
					          pick_lane(dl_chars, clip(int'(dl_count), MAX_TOKEN_CHARS), ",")};
			r = $urandom_range(0, 9);
			if (r < 6) begin
				repeat ($urandom_range(1, 5)) line_q = {line_q, word_char()};
			end else begin
				q = (nq > 0) ? $urandom_range(0, nq - 1) : 0;
				line_q = {line_q, lane(qt_chars, 2 * q)};
				if (r < 9)
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 3) == 0)
							repeat ($urandom_range(1, 9)) line_q = {line_q, CH_CR};
						else
							line_q = {line_q, letter()};
					end
				if ($urandom_range(0, 6) != 0)
					line_q = {line_q, lane(qt_chars, 2 * q + 1)};
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			c = pick_lane(cm_chars, clip(int'(cm_count), MAX_TOKEN_CHARS), "#");
			line_q = {line_q, c};
			if ($urandom_range(0, 1) == 1)
				line_q = {line_q, c};
			repeat ($urandom_range(0, 3)) line_q = {line_q, letter()};
		end
		r = $urandom_range(0, 9);
		eob_end = 1'b0;
		if (r < 5) begin
			line_q = {line_q, CH_LF};
		end else if (r < 7) begin
			line_q = {line_q, CH_NUL};
		end else begin
			eob_end = 1'b1;
			if (line_q.size() == 0)
				line_q = {line_q, letter()};
		end
		foreach (line_q[i])
			push_beat(line_q[i], eob_end && i == line_q.size() - 1);
	endtask

	initial begin
		clear_parse();
		dl_chars = '0; cm_chars = '0; qt_chars = '0;
		dl_count = '0; cm_count = '0; qt_pairs = '0;
		trim_on = 1'b0;
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Delimiters , ; |  comments # and doubled /  quotes "" and [].
		load_settings(64'h0000_0000_007C_3B2C, 4'd3, 64'h0000_0000_002F_2F23, 4'd3,
		              64'h0000_0000_5D5B_2222, 3'd2, 1'b1);
		set_idle(0);
		// Unquoted token with a dropped CR, a quote byte as content, a lone slash
		// decided by lookahead, then a doubled comment.
		push_beat("a", 1'b0); push_beat(CH_CR, 1'b0); push_beat("b", 1'b0);
		push_beat("\"", 1'b0); push_beat("/", 1'b0); push_beat("c", 1'b0);
		push_beat("/", 1'b0); push_beat("/", 1'b0); push_beat(CH_LF, 1'b0);
		// Top byte value, bracket quote with inner and trailing CRs, comment, NUL end.
		push_beat(8'hFF, 1'b0); push_beat(",", 1'b0); push_beat("[", 1'b0);
		push_beat(CH_CR, 1'b0); push_beat("x", 1'b0); push_beat(CH_CR, 1'b0);
		push_beat("]", 1'b0); push_beat("#", 1'b0); push_beat("k", 1'b0);
		push_beat(CH_NUL, 1'b0);
		// Empty quote, a quote left open at end of buffer, a comment byte last in its line.
		push_beat("\"", 1'b0); push_beat("\"", 1'b0); push_beat(CH_LF, 1'b0);
		push_beat("\"", 1'b0); push_beat("a", 1'b0); push_beat("b", 1'b1);
		push_beat("/", 1'b1);
		drain();

		for (int phase = 1; phase <= 7; phase++) begin
			case (phase)
				1: load_settings('1, 4'd0, '1, 4'd0, '1, 3'd0, 1'b0);
				2: load_settings(pool_word(0), 4'd8, pool_word(1), 4'd8, pool_word(2), 3'd4, 1'b1);
				3: load_settings(pool_word(0), 4'd15, pool_word(1), 4'd15, pool_word(2), 3'd7, 1'b0);
				default: load_settings(pool_word(0), 4'($urandom_range(0, 15)), pool_word(1),
				                       4'($urandom_range(0, 15)), pool_word(2),
				                       3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			endcase
			set_idle(phase % 4);
			phase_items = 0;
			while (phase_items < PHASE_BEATS) begin
				if ($urandom_range(0, 4) != 0)
					gen_line();
				else
					repeat ($urandom_range(3, 8)) push_beat(noise_char(), $urandom_range(0, 9) == 0);
			end
			drain();
		end

		if (errors == 0)
			$display("** line_tokenizer_quotes_comments: PASSED **");
		else
			$display("** line_tokenizer_quotes_comments: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/lt_pkg.sv
rtl/lt_cfg_regs.sv
rtl/lt_step.sv
rtl/lt_out_stage.sv
rtl/line_tokenizer_quotes_comments.sv
rtl/lt_checker.sv
verif/line_tokenizer_quotes_comments_tb.sv
